// ===== design/text_line_folder_assert.svh =====
// Assertion macros for the text line folder checker.
// Depends on nothing; included by the checker file only.
`ifndef TEXT_LINE_FOLDER_ASSERT_SVH
`define TEXT_LINE_FOLDER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TLF_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("tlf: implication check failed");

// Next-cycle implication, disabled while reset is asserted.
`define TLF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("tlf: next-cycle check failed");

`endif

// ===== design/tlf_pkg.sv =====
// Shared types and constants of the text line folder.
// No dependencies; imported by tlf_fold_ctrl, tlf_emitter, text_line_folder and tlf_checker.
package tlf_pkg;

	localparam logic [7:0] CH_SPACE   = 8'h20;
	localparam logic [7:0] CH_TAB     = 8'h09;
	localparam logic [7:0] CH_NEWLINE = 8'h0A;

	localparam logic CMD_TEXT  = 1'b0;
	localparam logic CMD_FLUSH = 1'b1;

	// What one request emits besides the buffered word.
	typedef struct packed {
		logic       pre_nl;     // newline ahead of the word
		logic [1:0] post_n;     // bytes after the word, 0..2
		logic [7:0] post0;
		logic [7:0] post1;
		logic       push_late;  // byte goes to the word store once the word is out
		logic [7:0] late_char;
	} tlf_plan_t;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_PRE  = 4'b0010,
		ST_WORD = 4'b0100,
		ST_POST = 4'b1000
	} tlf_state_t;

endpackage

// ===== design/tlf_stream_if.sv =====
// Valid/ready channels of the text line folder: text input and folded output.
// No dependencies.
interface tlf_in_if;
	logic       valid;
	logic       ready;
	logic       command;
	logic [7:0] char_in;

	modport source (output valid, output command, output char_in, input ready);
	modport sink (input valid, input command, input char_in, output ready);
endinterface

interface tlf_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_out;
	logic       last;

	modport source (output valid, output char_out, output last, input ready);
	modport sink (input valid, input char_out, input last, output ready);
endinterface

// ===== design/tlf_word_mem.sv =====
// Word store of the text line folder: one write port, one registered read port.
// No dependencies.
module tlf_word_mem #(
	parameter int DEPTH = 20,
	parameter int AW    = 5
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [7:0]    wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [7:0]    rdata
);

	logic [7:0] mem [DEPTH];
	logic [7:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== design/tlf_fold_ctrl.sv =====
// Folding decisions: column and word length registers, and the emit plan per request.
// Depends on tlf_pkg.
module tlf_fold_ctrl #(
	parameter int LINE_WIDTH  = 20,
	parameter int TAB_SPACING = 8,
	parameter int AW          = 5,
	parameter int WLW         = 5
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  logic              command,
	input  logic [7:0]        char_in,
	output tlf_pkg::tlf_plan_t plan,
	output logic [WLW-1:0]    word_n,
	output logic              has_emit,
	output logic              we,
	output logic [AW-1:0]     waddr,
	output logic [7:0]        wdata
);
	import tlf_pkg::*;

	localparam int CW = $clog2(LINE_WIDTH + TAB_SPACING + 2);
	// tab stops that an echoed tab can reach (column never past the width there)
	localparam int NTAB = (LINE_WIDTH + TAB_SPACING - 1) / TAB_SPACING;
	localparam logic [CW-1:0]  LW_C   = CW'(LINE_WIDTH);
	localparam logic [CW-1:0]  TS_C   = CW'(TAB_SPACING);
	localparam logic [WLW-1:0] WL_MAX = WLW'(LINE_WIDTH);

	logic [CW-1:0]  column_q, col_nxt, colp, col2, tab_next;
	logic [WLW-1:0] wl_q, wl_nxt;
	logic           is_blank, brk;

	always_comb begin
		colp     = column_q + CW'(1);
		is_blank = char_in inside {CH_SPACE, CH_TAB, CH_NEWLINE};
		brk      = (wl_q != '0) && (column_q > LW_C);
		col2     = brk ? CW'(wl_q) : colp;
		// smallest tab stop at or above col2
		tab_next = CW'(NTAB * TAB_SPACING);
		for (int k = NTAB; k >= 1; k--) begin
			if (CW'(k * TAB_SPACING) >= col2) begin
				tab_next = CW'(k * TAB_SPACING);
			end
		end

		plan           = '0;
		plan.late_char = char_in;
		word_n         = '0;
		col_nxt        = column_q;
		wl_nxt         = wl_q;
		we             = 1'b0;
		waddr          = wl_q[AW-1:0];
		wdata          = char_in;

		if (command == CMD_FLUSH) begin
			word_n  = wl_q;
			col_nxt = '0;
			wl_nxt  = '0;
		end else if (is_blank) begin
			word_n      = wl_q;
			plan.pre_nl = brk;
			wl_nxt      = '0;
			if (col2 <= LW_C) begin
				plan.post_n = 2'd1;
				plan.post0  = char_in;
				if (char_in == CH_TAB) begin
					col_nxt = tab_next;
				end else if (char_in == CH_NEWLINE) begin
					col_nxt = '0;
				end else begin
					col_nxt = col2;
				end
			end else begin
				// past the width: break the line, keep a tab or space as indent
				plan.post0 = CH_NEWLINE;
				if (char_in == CH_TAB) begin
					plan.post_n = 2'd2;
					plan.post1  = CH_TAB;
					col_nxt     = TS_C;
				end else if (char_in == CH_NEWLINE) begin
					plan.post_n = 2'd1;
					col_nxt     = '0;
				end else begin
					plan.post_n = 2'd2;
					plan.post1  = CH_SPACE;
					col_nxt     = CW'(1);
				end
			end
		end else if (colp <= LW_C) begin
			col_nxt = colp;
			if (wl_q < WL_MAX) begin
				we     = 1'b1;
				wl_nxt = wl_q + WLW'(1);
			end
		end else if (wl_q < WL_MAX) begin
			plan.pre_nl = 1'b1;
			we          = 1'b1;
			wl_nxt      = wl_q + WLW'(1);
			col_nxt     = CW'(wl_q) + CW'(1);
		end else begin
			// word fills the line: cut it, byte lands at entry 0 after the read-out
			word_n         = wl_q;
			plan.post_n    = 2'd1;
			plan.post0     = CH_NEWLINE;
			plan.push_late = 1'b1;
			wl_nxt         = WLW'(1);
			col_nxt        = CW'(1);
		end

		has_emit = plan.pre_nl || (word_n != '0) || (plan.post_n != 2'd0);
		we       = we && accept;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_q <= '0;
			wl_q     <= '0;
		end else if (accept) begin
			column_q <= col_nxt;
			wl_q     <= wl_nxt;
		end
	end

endmodule

// ===== design/tlf_emitter.sv =====
// Emit sequencer: newline, word read-out from the word store, trailing bytes,
// and the output register. Depends on tlf_pkg.
module tlf_emitter #(
	parameter int AW  = 5,
	parameter int WLW = 5
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  tlf_pkg::tlf_plan_t plan,
	input  logic [WLW-1:0]     word_n,
	output logic               idle,
	output logic               rd_en,
	output logic [AW-1:0]      rd_addr,
	input  logic [7:0]         rd_data,
	output logic               late_we,
	output logic [7:0]         late_char,
	output logic               out_valid,
	output logic [7:0]         out_char,
	output logic               out_last,
	input  logic               out_ready
);
	import tlf_pkg::*;

	tlf_state_t     state_q, state_nxt;
	logic [WLW-1:0] word_left_q, rd_left_q;
	logic [AW-1:0]  rd_addr_q;
	logic           rd_avail_q;
	logic [1:0]     post_n_q;
	logic [7:0]     post0_q, post1_q, late_char_q;
	logic           push_late_q;
	logic           out_valid_q, out_last_q;
	logic [7:0]     out_char_q;

	logic       out_free, load, load_word, load_post, finish, ld_last;
	logic [7:0] ld_char;

	always_comb begin
		out_free  = !out_valid_q || out_ready;
		state_nxt = state_q;
		load      = 1'b0;
		load_word = 1'b0;
		load_post = 1'b0;
		finish    = 1'b0;
		ld_char   = post0_q;
		ld_last   = 1'b0;
		rd_en     = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					if (plan.pre_nl) begin
						state_nxt = ST_PRE;
					end else if (word_n != '0) begin
						state_nxt = ST_WORD;
					end else begin
						state_nxt = ST_POST;
					end
				end
			end
			ST_PRE: begin
				if (out_free) begin
					load    = 1'b1;
					ld_char = CH_NEWLINE;
					ld_last = (word_left_q == '0) && (post_n_q == 2'd0);
					if (word_left_q != '0) begin
						state_nxt = ST_WORD;
					end else if (post_n_q != 2'd0) begin
						state_nxt = ST_POST;
					end else begin
						state_nxt = ST_IDLE;
						finish    = 1'b1;
					end
				end
			end
			ST_WORD: begin
				// keep one read in flight ahead of the output register
				rd_en = (rd_left_q != '0) && (!rd_avail_q || out_free);
				if (rd_avail_q && out_free) begin
					load      = 1'b1;
					load_word = 1'b1;
					ld_char   = rd_data;
					ld_last   = (word_left_q == WLW'(1)) && (post_n_q == 2'd0);
					if (word_left_q == WLW'(1)) begin
						if (post_n_q != 2'd0) begin
							state_nxt = ST_POST;
						end else begin
							state_nxt = ST_IDLE;
							finish    = 1'b1;
						end
					end
				end
			end
			ST_POST: begin
				if (out_free) begin
					load      = 1'b1;
					load_post = 1'b1;
					ld_char   = post0_q;
					ld_last   = (post_n_q == 2'd1);
					if (post_n_q == 2'd1) begin
						state_nxt = ST_IDLE;
						finish    = 1'b1;
					end
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			word_left_q <= '0;
			rd_left_q   <= '0;
			rd_addr_q   <= '0;
			rd_avail_q  <= 1'b0;
			post_n_q    <= 2'd0;
			push_late_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (state_q == ST_IDLE && start) begin
				word_left_q <= word_n;
				rd_left_q   <= word_n;
				rd_addr_q   <= '0;
				post_n_q    <= plan.post_n;
				push_late_q <= plan.push_late;
			end else begin
				if (rd_en) begin
					rd_left_q <= rd_left_q - WLW'(1);
					rd_addr_q <= rd_addr_q + AW'(1);
				end
				if (load_word) begin
					word_left_q <= word_left_q - WLW'(1);
				end
				if (load_post) begin
					post_n_q <= post_n_q - 2'd1;
				end
			end
			if (rd_en) begin
				rd_avail_q <= 1'b1;
			end else if (load_word) begin
				rd_avail_q <= 1'b0;
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			post0_q     <= plan.post0;
			post1_q     <= plan.post1;
			late_char_q <= plan.late_char;
		end else if (load_post) begin
			post0_q <= post1_q;
		end
		if (load) begin
			out_char_q <= ld_char;
			out_last_q <= ld_last;
		end
	end

	assign idle      = (state_q == ST_IDLE);
	assign rd_addr   = rd_addr_q;
	assign late_we   = finish && push_late_q;
	assign late_char = late_char_q;
	assign out_valid = out_valid_q;
	assign out_char  = out_char_q;
	assign out_last  = out_last_q;

endmodule

// ===== design/text_line_folder.sv =====
// Top level of the text line folder.
// Depends on tlf_pkg, tlf_stream_if, tlf_word_mem, tlf_fold_ctrl, tlf_emitter.
//
// Folds a byte stream into lines near LINE_WIDTH columns. A request is a
// text byte (command 0) or a flush (command 1) that emits the buffered word
// and returns to the reset state. Each request yields 0 to LINE_WIDTH+2
// output bytes, the final one marked by last. The word lives in a
// LINE_WIDTH-entry store with a registered read, and output runs at one
// byte per cycle while the output side is ready. The input is held off
// while a request's bytes are still being emitted; the last byte may wait
// in the output register while the next request enters.
module text_line_folder #(
	parameter int LINE_WIDTH  = 20,
	parameter int TAB_SPACING = 8
) (
	input logic       clk,
	input logic       arst_n,
	tlf_in_if.sink    text,
	tlf_out_if.source folded
);
	import tlf_pkg::*;

	localparam int AW  = $clog2(LINE_WIDTH);
	localparam int WLW = $clog2(LINE_WIDTH + 1);

	tlf_plan_t      plan;
	logic [WLW-1:0] word_n;
	logic           has_emit, idle, accept;
	logic           ctrl_we, late_we, mem_we, rd_en;
	logic [AW-1:0]  ctrl_waddr, mem_waddr, rd_addr;
	logic [7:0]     ctrl_wdata, late_char, mem_wdata, rd_data;

	assign accept = text.valid && idle;
	assign text.ready = idle;

	tlf_fold_ctrl #(
		.LINE_WIDTH  (LINE_WIDTH),
		.TAB_SPACING (TAB_SPACING),
		.AW          (AW),
		.WLW         (WLW)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.command  (text.command),
		.char_in  (text.char_in),
		.plan     (plan),
		.word_n   (word_n),
		.has_emit (has_emit),
		.we       (ctrl_we),
		.waddr    (ctrl_waddr),
		.wdata    (ctrl_wdata)
	);

	// writes at accept and the deferred write never fall in the same cycle
	assign mem_we    = ctrl_we || late_we;
	assign mem_waddr = late_we ? '0 : ctrl_waddr;
	assign mem_wdata = late_we ? late_char : ctrl_wdata;

	tlf_word_mem #(
		.DEPTH (LINE_WIDTH),
		.AW    (AW)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	tlf_emitter #(
		.AW  (AW),
		.WLW (WLW)
	) u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (accept && has_emit),
		.plan      (plan),
		.word_n    (word_n),
		.idle      (idle),
		.rd_en     (rd_en),
		.rd_addr   (rd_addr),
		.rd_data   (rd_data),
		.late_we   (late_we),
		.late_char (late_char),
		.out_valid (folded.valid),
		.out_char  (folded.char_out),
		.out_last  (folded.last),
		.out_ready (folded.ready)
	);

endmodule

// ===== design/tlf_checker.sv =====
// Port-level checks of the text line folder, bound to the top level.
// Depends on tlf_pkg and text_line_folder_assert.svh.
`include "text_line_folder_assert.svh"

module tlf_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       in_command,
	input logic [7:0] in_char,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] out_char,
	input logic       out_last
);
	import tlf_pkg::*;

	logic blank_req;

	assign blank_req = in_valid && in_ready && (in_command == CMD_TEXT) &&
		(in_char == CH_SPACE || in_char == CH_TAB || in_char == CH_NEWLINE);

	// a stalled result stays offered
	`TLF_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid)

	// and keeps its payload
	`TLF_ASSERT_NEXT(a_out_stable, clk, arst_n, out_valid && !out_ready, $stable(out_char) && $stable(out_last))

	// a blank always emits, so the input is held off right after it
	`TLF_ASSERT_NEXT(a_blank_busy, clk, arst_n, blank_req, !in_ready)

	// while a non-final byte is offered, the request is still in progress
	`TLF_ASSERT_IMPLIES(a_no_early_req, clk, arst_n, out_valid && !out_last, !in_ready)

endmodule

bind text_line_folder tlf_checker u_tlf_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (text.valid),
	.in_ready   (text.ready),
	.in_command (text.command),
	.in_char    (text.char_in),
	.out_valid  (folded.valid),
	.out_ready  (folded.ready),
	.out_char   (folded.char_out),
	.out_last   (folded.last)
);

// ===== test/tb.sv =====
// Self-checking bench for text_line_folder: directed script, then random text.
// Depends on tlf_pkg, tlf_stream_if and the design files.
`timescale 1ns / 1ps

module tb;
	import tlf_pkg::*;

	localparam int LINE_W       = 20;
	localparam int TAB_W        = 8;
	localparam int PREDICT      = -1;
	localparam int RAND_PER_PH  = 90;
	localparam int HOLD_CYCLES  = 400;
	localparam int LIMIT_CYCLES = 500000;

	typedef struct packed {
		logic [7:0] ch;
		logic       last;
	} fold_byte_t;

	// One row of the directed script; typed_n = PREDICT leaves it to the predictor.
	typedef struct packed {
		logic       cmd;
		logic [7:0] ch;
		int         reps;
		int         typed_n;
		logic [7:0] t0;
	} step_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	tlf_in_if  text_if ();
	tlf_out_if folded_if ();

	text_line_folder #(
		.LINE_WIDTH (LINE_W),
		.TAB_SPACING(TAB_W)
	) i_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.text  (text_if),
		.folded(folded_if)
	);

	always #10 clk = ~clk;

	// predictor state
	logic [7:0] word_buf [LINE_W];
	int         word_len = 0;
	int         col = 0;
	int         pred_n;
	bit         pred_keep = 1'b1;
	fold_byte_t fold_q [$];

	int errors = 0;
	int cycle_cnt = 0;
	int random_sent = 0;
	int src_idle_pct = 0;
	int snk_stall_pct = 0;
	bit long_hold = 1'b0;

	function automatic void exp_push(input logic [7:0] b);
		if (pred_keep)
			fold_q.push_back('{ch: b, last: 1'b0});
		pred_n++;
	endfunction

	function automatic void exp_word();
		for (int k = 0; k < word_len; k++)
			exp_push(word_buf[k]);
	endfunction

	function automatic void word_add(input logic [7:0] b);
		if (word_len < LINE_W) begin
			word_buf[word_len] = b;
			word_len++;
		end
	endfunction

	function automatic void fold_predict(input logic cmd, input logic [7:0] c);
		int base;
		pred_n = 0;
		if (cmd == CMD_FLUSH) begin
			exp_word();
			word_len = 0;
			col = 0;
		end else begin
			col++;
			if (c == CH_SPACE || c == CH_TAB || c == CH_NEWLINE) begin
				if (word_len > 0) begin
					if (col - 1 > LINE_W) begin
						exp_push(CH_NEWLINE);
						exp_word();
						col = word_len;
					end else begin
						exp_word();
					end
					word_len = 0;
				end
				if (col <= LINE_W) begin
					exp_push(c);
					if (c == CH_TAB) begin
						base = (col == 0) ? 0 : col - 1;
						col = (base / TAB_W + 1) * TAB_W;
					end else if (c == CH_NEWLINE) begin
						col = 0;
					end
				end else begin
					// past the width: blank turns into a break
					exp_push(CH_NEWLINE);
					if (c == CH_TAB) begin
						exp_push(CH_TAB);
						col = TAB_W;
					end else if (c == CH_SPACE) begin
						exp_push(CH_SPACE);
						col = 1;
					end else begin
						col = 0;
					end
				end
			end else begin
				if (col <= LINE_W) begin
					word_add(c);
				end else if (word_len < LINE_W) begin
					exp_push(CH_NEWLINE);
					word_add(c);
					col = word_len;
				end else begin
					// word fills the line: cut it off
					exp_word();
					exp_push(CH_NEWLINE);
					word_len = 0;
					word_add(c);
					col = 1;
				end
			end
		end
		if (pred_keep && pred_n > 0)
			fold_q[fold_q.size() - 1].last = 1'b1;
	endfunction

	// Called at a rising edge; leaves valid high so back-to-back requests need no toggle.
	task automatic send_req(input logic cmd, input logic [7:0] c);
		bit took;
		while ($urandom_range(99) < src_idle_pct) begin
			text_if.valid <= 1'b0;
			@(posedge clk);
		end
		text_if.valid   <= 1'b1;
		text_if.command <= cmd;
		text_if.char_in <= c;
		do begin
			@(negedge clk);
			took = text_if.ready;
			@(posedge clk);
		end while (!took);
		fold_predict(cmd, c);
	endtask

	step_t script [27] = '{
		'{CMD_FLUSH, 8'h00,       1, 0,       8'h00},  // empty flush after reset
		'{CMD_TEXT,  CH_SPACE,    1, 1,       CH_SPACE},
		'{CMD_TEXT,  8'h00,       1, 0,       8'h00},  // zero byte is a glyph
		'{CMD_TEXT,  8'hFF,       1, 0,       8'h00},
		'{CMD_TEXT,  CH_TAB,      1, PREDICT, 8'h00},
		'{CMD_TEXT,  CH_NEWLINE,  1, 1,       CH_NEWLINE},
		'{CMD_TEXT,  "x",        21, PREDICT, 8'h00},  // full-width word cut off
		'{CMD_TEXT,  "y",        19, PREDICT, 8'h00},
		'{CMD_TEXT,  CH_SPACE,    1, PREDICT, 8'h00},
		'{CMD_TEXT,  "z",        18, PREDICT, 8'h00},
		'{CMD_TEXT,  CH_TAB,      1, PREDICT, 8'h00},  // tab rounds column past width
		'{CMD_TEXT,  CH_NEWLINE,  1, PREDICT, 8'h00},
		'{CMD_TEXT,  "z",        18, PREDICT, 8'h00},
		'{CMD_TEXT,  CH_TAB,      1, PREDICT, 8'h00},
		'{CMD_TEXT,  CH_TAB,      1, PREDICT, 8'h00},  // break plus tab
		'{CMD_TEXT,  "w",        12, PREDICT, 8'h00},
		'{CMD_TEXT,  "w",         1, PREDICT, 8'h00},  // word moves to a new line
		'{CMD_TEXT,  CH_SPACE,    1, PREDICT, 8'h00},
		'{CMD_TEXT,  "v",         3, PREDICT, 8'h00},
		'{CMD_TEXT,  CH_TAB,      1, PREDICT, 8'h00},
		'{CMD_TEXT,  CH_SPACE,    1, PREDICT, 8'h00},  // break plus space
		'{CMD_TEXT,  "u",         5, PREDICT, 8'h00},
		'{CMD_FLUSH, 8'hA5,       1, PREDICT, 8'h00},  // flush releases the word
		'{CMD_FLUSH, 8'hFF,       1, 0,       8'h00},
		'{CMD_TEXT,  CH_NEWLINE,  1, 1,       CH_NEWLINE},
		'{CMD_TEXT,  8'h00,       1, 0,       8'h00},
		'{CMD_FLUSH, 8'h00,       1, 1,       8'h00}
	};

	initial begin
		int         len;
		int         r;
		logic [7:0] c;
		text_if.valid   = 1'b0;
		text_if.command = CMD_TEXT;
		text_if.char_in = 8'h00;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < $size(script); i++) begin
			repeat (script[i].reps) begin
				pred_keep = (script[i].typed_n == PREDICT);
				send_req(script[i].cmd, script[i].ch);
				if (script[i].typed_n == 1)
					fold_q.push_back('{ch: script[i].t0, last: 1'b1});
			end
		end
		pred_keep = 1'b1;

		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin
					src_idle_pct = 0;
					snk_stall_pct = 0;
					long_hold = 1'b1;
				end
				1: begin
					src_idle_pct = 80;
					snk_stall_pct = 0;
				end
				2: begin
					src_idle_pct = 0;
					snk_stall_pct = 80;
				end
				default: begin
					src_idle_pct = 16;
					snk_stall_pct = 16;
				end
			endcase
			while (random_sent < (ph + 1) * RAND_PER_PH) begin
				r = $urandom_range(99);
				if (r < 4) begin
					send_req(CMD_FLUSH, 8'($urandom));
					random_sent++;
				end else if (r < 10) begin
					send_req(CMD_TEXT, 8'($urandom));
					random_sent++;
				end else begin
					// mostly short words, a few that run into the width
					len = ($urandom_range(9) == 0) ? $urandom_range(18, 24) : $urandom_range(1, 9);
					repeat (len) begin
						do c = 8'($urandom);
						while (c == CH_SPACE || c == CH_TAB || c == CH_NEWLINE);
						send_req(CMD_TEXT, c);
					end
					case ($urandom_range(2))
						0: send_req(CMD_TEXT, CH_SPACE);
						1: send_req(CMD_TEXT, CH_TAB);
						default: send_req(CMD_TEXT, CH_NEWLINE);
					endcase
					random_sent += len + 1;
				end
			end
		end

		text_if.valid <= 1'b0;
		while (fold_q.size() != 0)
			@(posedge clk);
		repeat (50) @(posedge clk);
		if (errors == 0 && fold_q.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

	// output side: random stalls plus one long hold-off to back up the input
	initial begin
		folded_if.ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (long_hold) begin
				folded_if.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				long_hold = 1'b0;
			end
			folded_if.ready <= ($urandom_range(99) >= snk_stall_pct);
		end
	end

	// sampled mid-cycle, so the handshake seen here is the one taken at the next edge
	always @(negedge clk) begin
		fold_byte_t want;
		if (arst_n && folded_if.valid && folded_if.ready) begin
			if (fold_q.size() == 0) begin
				errors++;
				$display("%0t: unexpected byte: expected none, actual char %h last %b",
					$time, folded_if.char_out, folded_if.last);
			end else begin
				want = fold_q.pop_front();
				if (folded_if.char_out !== want.ch) begin
					errors++;
					$display("%0t: char_out mismatch: expected %h, actual %h",
						$time, want.ch, folded_if.char_out);
				end
				if (folded_if.last !== want.last) begin
					errors++;
					$display("%0t: last mismatch: expected %b, actual %b",
						$time, want.last, folded_if.last);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > LIMIT_CYCLES) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

endmodule

// ===== filelist.f =====
+incdir+design
design/tlf_pkg.sv
design/tlf_stream_if.sv
design/tlf_word_mem.sv
design/tlf_fold_ctrl.sv
design/tlf_emitter.sv
design/text_line_folder.sv
design/tlf_checker.sv
test/tb.sv
